// ===== hw/rtl/srfg_pkg.sv =====
// Package of the section ramp frame generator.
// Holds the limits, the state type and the clamp helpers.
// No dependencies; the interfaces and the top level import it.
package srfg_pkg;

    // Value limits and section framing.
    localparam int unsigned FREQ_MIN       = 10;
    localparam int unsigned FREQ_MAX       = 240;
    localparam int unsigned STRENGTH_MAX   = 100;
    localparam int unsigned SUBS_PER_FRAME = 4;
    localparam int unsigned MAX_FRAMES_DEF = 64;

    // Field widths.
    localparam int unsigned DUR_W  = 16;
    localparam int unsigned FREQ_W = 8;
    localparam int unsigned STR_W  = 7;
    localparam int unsigned IN_W   = 8;

    // floor(d / 100) = (d * DUR_RECIP) >> DUR_SHIFT for every 16-bit d.
    localparam int unsigned DUR_RECIP_W = 17;
    localparam logic [DUR_RECIP_W-1:0] DUR_RECIP = 17'd83887;
    localparam int unsigned DUR_SHIFT = 23;
    localparam int unsigned DUR_Q_W   = 10;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_MULF,
        S_MULS,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    // Clamp a raw frequency code to the legal range.
    function automatic logic [FREQ_W-1:0] clamp_freq(input logic [IN_W-1:0] v);
        logic [FREQ_W-1:0] r;
        if (v > IN_W'(FREQ_MAX)) begin
            r = FREQ_W'(FREQ_MAX);
        end else if (v < IN_W'(FREQ_MIN)) begin
            r = FREQ_W'(FREQ_MIN);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Clamp a raw strength to the legal range.
    function automatic logic [STR_W-1:0] clamp_str(input logic [IN_W-1:0] v);
        logic [STR_W-1:0] r;
        if (v > IN_W'(STRENGTH_MAX)) begin
            r = STR_W'(STRENGTH_MAX);
        end else begin
            r = v[STR_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/srfg_ifs.sv =====
// Channel interfaces of the section ramp frame generator.
// Depends on srfg_pkg for the field widths.

// Section channel: one word describes one waveform section.
interface srfg_sect_if
    import srfg_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [DUR_W-1:0]  sect_dur;
    logic [IN_W-1:0]   freq_from;
    logic [IN_W-1:0]   freq_to;
    logic [IN_W-1:0]   str_from;
    logic [IN_W-1:0]   str_to;

    modport source (
        output valid, sect_dur, freq_from, freq_to, str_from, str_to,
        input  ready
    );
    modport sink (
        input  valid, sect_dur, freq_from, freq_to, str_from, str_to,
        output ready
    );
endinterface

// Frame channel: one word carries four sub-steps of both quantities.
interface srfg_frame_if
    import srfg_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_sub0;
    logic [FREQ_W-1:0] freq_sub1;
    logic [FREQ_W-1:0] freq_sub2;
    logic [FREQ_W-1:0] freq_sub3;
    logic [STR_W-1:0]  strength_sub0;
    logic [STR_W-1:0]  strength_sub1;
    logic [STR_W-1:0]  strength_sub2;
    logic [STR_W-1:0]  strength_sub3;
    logic              last_frame;

    modport source (
        output valid, freq_sub0, freq_sub1, freq_sub2, freq_sub3,
               strength_sub0, strength_sub1, strength_sub2, strength_sub3, last_frame,
        input  ready
    );
    modport sink (
        input  valid, freq_sub0, freq_sub1, freq_sub2, freq_sub3,
               strength_sub0, strength_sub1, strength_sub2, strength_sub3, last_frame,
        output ready
    );
endinterface

// ===== hw/rtl/section_ramp_frame_generator.sv =====
// Top level of the section ramp frame generator.
// Depends on srfg_pkg and on the interfaces in srfg_ifs.sv.
//
//   channel   modport   direction   word
//   i_sect    sink      in          duration, start/end frequency, start/end strength
//   o_frame   source    out         four frequency and four strength sub-steps, last flag
//
// A section passes the setup states S_LEN, S_MULF and S_MULS, then builds each frame from
// eight values, each loaded in S_LOAD and found bit by bit in S_DIV by the shared restoring
// divider, and hands the frame to the output register in S_EMIT. i_sect.ready is high only
// between sections. A stalled output holds the sequencer in its hand-off state; nothing is
// lost. Reset is synchronous and clears the sequencer and the output valid flag only.
module section_ramp_frame_generator
    import srfg_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srfg_sect_if.sink    i_sect,
    srfg_frame_if.source o_frame
);

    // Widths that follow from the frame limit.
    localparam int unsigned NW   = $clog2(MAX_FRAMES + 1);
    localparam int unsigned DENW = NW + 2;
    localparam int unsigned DW   = NW + 3;
    localparam int unsigned NUMW = FREQ_W + DENW;
    localparam int unsigned AW   = DENW + 9;
    localparam int unsigned DLW  = FREQ_W + 1;
    localparam int unsigned QBW  = $clog2(FREQ_W);

    t_state               r_state;
    t_state               n_state;

    logic [DUR_W-1:0]     r_dur;
    logic [FREQ_W-1:0]    r_fs;
    logic [FREQ_W-1:0]    r_fe;
    logic [STR_W-1:0]     r_ss;
    logic [STR_W-1:0]     r_se;
    logic [NW-1:0]        r_nfr;
    logic [NUMW-1:0]      r_nf;
    logic [NUMW-1:0]      r_ns;
    logic [AW-1:0]        r_rem;
    logic [FREQ_W-1:0]    r_q;
    logic [QBW-1:0]       r_bit;
    logic [1:0]           r_unit;
    logic                 r_field;
    logic [NW-1:0]        r_frame;
    logic [FREQ_W-1:0]    r_fq [SUBS_PER_FRAME];
    logic [STR_W-1:0]     r_sq [SUBS_PER_FRAME];
    logic                 r_ov;
    logic [FREQ_W-1:0]    r_of [SUBS_PER_FRAME];
    logic [STR_W-1:0]     r_os [SUBS_PER_FRAME];
    logic                 r_olast;

    logic                 w_accept;
    logic                 w_push;
    logic                 w_last;
    logic [DENW-1:0]      w_den;
    logic [DW-1:0]        w_div;
    logic [DUR_W+DUR_RECIP_W-1:0] w_prod;
    logic [DUR_Q_W-1:0]   w_q100;
    logic [NW-1:0]        w_nfr;
    logic [FREQ_W-1:0]    w_mul_a;
    logic [NUMW-1:0]      w_mul;
    logic [AW-1:0]        w_shift;
    logic [AW:0]          w_trial;
    logic                 w_take;
    logic [FREQ_W-1:0]    w_qn;
    logic [DLW-1:0]       w_df;
    logic [DLW-1:0]       w_ds;
    logic [NUMW-1:0]      w_df_x;
    logic [NUMW-1:0]      w_ds_x;

    // Handshakes.
    assign w_accept       = i_sect.valid && i_sect.ready;
    assign i_sect.ready   = (r_state == S_IDLE);
    assign w_push         = (r_state == S_EMIT) && (!r_ov || o_frame.ready);
    assign w_last         = (r_frame == (r_nfr - NW'(1)));

    // Denominator of the ramp (4N) and divisor of the rounded quotient (8N).
    assign w_den = {r_nfr, 2'b00};
    assign w_div = {w_den, 1'b0};

    // Frame count: duration / 100, forced into 1..MAX_FRAMES.
    assign w_prod = DUR_W'(r_dur) * DUR_RECIP;
    assign w_q100 = DUR_Q_W'(w_prod >> DUR_SHIFT);
    always_comb begin
        if (w_q100 == '0) begin
            w_nfr = NW'(1);
        end else if (w_q100 > DUR_Q_W'(MAX_FRAMES)) begin
            w_nfr = NW'(MAX_FRAMES);
        end else begin
            w_nfr = NW'(w_q100);
        end
    end

    // Shared multiplier for the two start numerators (start value times 4N).
    assign w_mul_a = (r_state == S_MULF) ? r_fs : {1'b0, r_ss};
    assign w_mul   = NUMW'(w_mul_a) * NUMW'(w_den);

    // Per sub-step numerator increments, sign-extended.
    assign w_df   = {1'b0, r_fe} - {1'b0, r_fs};
    assign w_ds   = {2'b00, r_se} - {2'b00, r_ss};
    assign w_df_x = {{(NUMW-DLW){w_df[DLW-1]}}, w_df};
    assign w_ds_x = {{(NUMW-DLW){w_ds[DLW-1]}}, w_ds};

    // One restoring step of the shared divider.
    assign w_shift = AW'(w_div) << r_bit;
    assign w_trial = {1'b0, r_rem} - {1'b0, w_shift};
    assign w_take  = !w_trial[AW];
    assign w_qn    = r_q | (FREQ_W'(w_take) << r_bit);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LEN;
                end
            end
            S_LEN:  n_state = S_MULF;
            S_MULF: n_state = S_MULS;
            S_MULS: n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (r_bit == '0) begin
                    if (r_field && (r_unit == 2'(SUBS_PER_FRAME - 1))) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_EMIT: begin
                if (w_push) begin
                    n_state = w_last ? S_IDLE : S_LOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers, advanced under the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_dur   <= i_sect.sect_dur;
                    r_fs    <= clamp_freq(i_sect.freq_from);
                    r_fe    <= clamp_freq(i_sect.freq_to);
                    r_ss    <= clamp_str(i_sect.str_from);
                    r_se    <= clamp_str(i_sect.str_to);
                    r_frame <= '0;
                    r_unit  <= '0;
                    r_field <= 1'b0;
                end
            end
            S_LEN:  r_nfr <= w_nfr;
            S_MULF: r_nf  <= w_mul;
            S_MULS: r_ns  <= w_mul;
            S_LOAD: begin
                // Rounded quotient: (2*num + den) / (2*den).
                r_rem <= AW'({r_field ? r_ns : r_nf, 1'b0}) + AW'(w_den);
                r_q   <= '0;
                r_bit <= QBW'(FREQ_W - 1);
            end
            S_DIV: begin
                if (w_take) begin
                    r_rem <= w_trial[AW-1:0];
                end
                r_q   <= w_qn;
                r_bit <= r_bit - QBW'(1);
                if (r_bit == '0) begin
                    if (r_field) begin
                        r_sq[r_unit] <= w_qn[STR_W-1:0];
                        r_nf         <= r_nf + w_df_x;
                        r_ns         <= r_ns + w_ds_x;
                        r_unit       <= r_unit + 2'd1;
                    end else begin
                        r_fq[r_unit] <= w_qn;
                    end
                    r_field <= !r_field;
                end
            end
            S_EMIT: begin
                if (w_push) begin
                    r_frame <= r_frame + NW'(1);
                end
            end
            default: ;
        endcase
    end

    // Output register: loaded with a finished frame, held until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_push) begin
            r_ov <= 1'b1;
        end else if (o_frame.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_of    <= r_fq;
            r_os    <= r_sq;
            r_olast <= w_last;
        end
    end

    assign o_frame.valid         = r_ov;
    assign o_frame.freq_sub0     = r_of[0];
    assign o_frame.freq_sub1     = r_of[1];
    assign o_frame.freq_sub2     = r_of[2];
    assign o_frame.freq_sub3     = r_of[3];
    assign o_frame.strength_sub0 = r_os[0];
    assign o_frame.strength_sub1 = r_os[1];
    assign o_frame.strength_sub2 = r_os[2];
    assign o_frame.strength_sub3 = r_os[3];
    assign o_frame.last_frame    = r_olast;

`ifndef ASSERT_OFF
    // The frame index never passes the frame count while frames are being built.
    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_DIV || r_state == S_EMIT) |-> (r_frame < r_nfr))
        else $error("frame index beyond frame count");

    // The frame count stays within 1..MAX_FRAMES once set.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_DIV || r_state == S_EMIT)
        |-> (r_nfr != '0 && r_nfr <= NW'(MAX_FRAMES)))
        else $error("frame count out of range");

    // Handing over the last frame ends the section.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_last) |=> (r_state == S_IDLE && o_frame.last_frame))
        else $error("section did not end after its last frame");

    // A frequency quotient never leaves the legal range.
    a_freq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit == '0 && !r_field)
        |-> (w_qn >= FREQ_W'(FREQ_MIN) && w_qn <= FREQ_W'(FREQ_MAX)))
        else $error("frequency sub-step out of range");
`endif

endmodule
